// ===== hw/rtl/cal_pkg.sv =====
// Shared types, constants and helper functions of the calendar date counter.
// Used by cal_cfg, cal_next and calendar_date_counter_unit; depends on nothing.
`default_nettype none

package cal_pkg;

	typedef enum logic [1:0] {
		REQ_TICK = 2'd0,
		REQ_SET  = 2'd1,
		REQ_READ = 2'd2
	} req_type_t;

	typedef enum logic [2:0] {
		FLD_HOUR    = 3'd0,
		FLD_MINUTE  = 3'd1,
		FLD_SECOND  = 3'd2,
		FLD_YEAR    = 3'd3,
		FLD_MONTH   = 3'd4,
		FLD_DAY     = 3'd5,
		FLD_WEEKDAY = 3'd6
	} field_sel_t;

	// Register indexes as decoded from paddr[2].
	localparam logic REG_RUN_PAUSED     = 1'b0;
	localparam logic REG_PRESCALE_LIMIT = 1'b1;

	localparam int unsigned ADDR_W = 3;

	localparam logic [9:0]  PRESCALE_LIMIT_RST = 10'd499;
	localparam logic [15:0] YEAR_RST           = 16'd2018;
	localparam logic [3:0]  MONTH_JAN          = 4'd1;
	localparam logic [3:0]  MONTH_FEB          = 4'd2;
	localparam logic [3:0]  MONTH_DEC          = 4'd12;
	localparam logic [4:0]  DAY_FIRST          = 5'd1;
	localparam logic [4:0]  DAY_MAX            = 5'd31;
	localparam logic [2:0]  WEEKDAY_FIRST      = 3'd1;
	localparam logic [2:0]  WEEKDAY_LAST       = 3'd7;

	// Multiplicative inverse of 25 modulo 2^16. A 16-bit value is a multiple of 25
	// exactly when its product with the inverse, modulo 2^16, is at most 65535 / 25.
	localparam logic [15:0] INV_25     = 16'd23593;
	localparam logic [15:0] DIV_25_MAX = 16'd2621;

	typedef struct packed {
		logic       run_paused;
		logic [9:0] prescale_limit;
	} cal_cfg_t;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [2:0]         field_select;
		logic signed [15:0] set_value;
	} cal_req_t;

	typedef struct packed {
		logic [9:0]         prescale_count;
		logic signed [15:0] hour;
		logic signed [15:0] minute;
		logic signed [15:0] second;
		logic [15:0]        year;
		logic [3:0]         month;
		logic [4:0]         day;
		logic [2:0]         weekday;
	} cal_state_t;

	function automatic logic [4:0] days_in_month(input logic [3:0] month, input logic leap);
		logic [4:0] len;
		unique case (month)
			4'd1:    len = 5'd31;
			4'd2:    len = leap ? 5'd29 : 5'd28;
			4'd3:    len = 5'd31;
			4'd4:    len = 5'd30;
			4'd5:    len = 5'd31;
			4'd6:    len = 5'd30;
			4'd7:    len = 5'd31;
			4'd8:    len = 5'd31;
			4'd9:    len = 5'd30;
			4'd10:   len = 5'd31;
			4'd11:   len = 5'd30;
			4'd12:   len = 5'd31;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cal_cfg.sv =====
// APB-style register file of the calendar date counter: run_paused and prescale_limit.
// Depends on cal_pkg.
`default_nettype none

module cal_cfg (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [cal_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output logic      [31:0]                prdata,
	output logic                            pready,
	output cal_pkg::cal_cfg_t               cfg
);

	logic       wr_en;
	logic       run_paused_q;
	logic [9:0] prescale_limit_q;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_paused_q     <= 1'b0;
			prescale_limit_q <= cal_pkg::PRESCALE_LIMIT_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				cal_pkg::REG_RUN_PAUSED:     run_paused_q     <= pwdata[0];
				cal_pkg::REG_PRESCALE_LIMIT: prescale_limit_q <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			cal_pkg::REG_RUN_PAUSED:     prdata = {31'd0, run_paused_q};
			cal_pkg::REG_PRESCALE_LIMIT: prdata = {22'd0, prescale_limit_q};
			default:                     prdata = 32'd0;
		endcase
	end

	assign cfg.run_paused     = run_paused_q;
	assign cfg.prescale_limit = prescale_limit_q;

endmodule

`default_nettype wire

// ===== hw/rtl/cal_next.sv =====
// Next-state logic of the calendar: prescale count, second and weekday steps, day/month/year
// rollover with the Gregorian leap test, and single-field sets. Depends on cal_pkg.
`default_nettype none

module cal_next (
	input  wire cal_pkg::cal_cfg_t   cfg,
	input  wire cal_pkg::cal_state_t cur,
	input  wire cal_pkg::cal_req_t   req,
	output cal_pkg::cal_state_t      nxt,
	output logic                     advanced
);

	logic [15:0] year_prod;
	logic        div_25;
	logic        leap;
	logic [4:0]  month_len;
	logic [5:0]  day_inc;
	logic        at_limit;
	logic        month_ok;
	logic        day_ok;
	logic        weekday_ok;

	// Divisibility by 25 through the modular inverse; 4, 16 are plain masks.
	assign year_prod = cur.year * cal_pkg::INV_25;
	assign div_25    = year_prod <= cal_pkg::DIV_25_MAX;
	assign leap      = (cur.year[1:0] == 2'd0) && (!div_25 || (cur.year[3:0] == 4'd0));
	assign month_len = cal_pkg::days_in_month(cur.month, leap);
	assign day_inc   = {1'b0, cur.day} + 6'd1;
	assign at_limit  = cur.prescale_count >= cfg.prescale_limit;

	// Range checks on the signed set value: the sign bit must be clear.
	assign month_ok   = !req.set_value[15] && (req.set_value[15:4] == 12'd0)
		&& (req.set_value[3:0] >= cal_pkg::MONTH_JAN) && (req.set_value[3:0] <= cal_pkg::MONTH_DEC);
	assign day_ok     = !req.set_value[15] && (req.set_value[15:5] == 11'd0)
		&& (req.set_value[4:0] >= cal_pkg::DAY_FIRST) && (req.set_value[4:0] <= cal_pkg::DAY_MAX);
	assign weekday_ok = !req.set_value[15] && (req.set_value[15:3] == 13'd0)
		&& (req.set_value[2:0] >= cal_pkg::WEEKDAY_FIRST);

	always_comb begin
		nxt      = cur;
		advanced = 1'b0;
		unique case (req.req_type)
			cal_pkg::REQ_TICK: begin
				if (at_limit && !cfg.run_paused) begin
					advanced           = 1'b1;
					nxt.prescale_count = 10'd0;
					nxt.second         = cur.second + 16'sd1;
					nxt.weekday        = (cur.weekday == cal_pkg::WEEKDAY_LAST) ?
						cal_pkg::WEEKDAY_FIRST : cur.weekday + 3'd1;
					if (day_inc > {1'b0, month_len}) begin
						nxt.day = cal_pkg::DAY_FIRST;
						if (cur.month >= cal_pkg::MONTH_DEC) begin
							nxt.month = cal_pkg::MONTH_JAN;
							nxt.year  = cur.year + 16'd1;
						end else begin
							nxt.month = cur.month + 4'd1;
						end
					end else begin
						nxt.day = day_inc[4:0];
					end
				end else if (!at_limit) begin
					nxt.prescale_count = cur.prescale_count + 10'd1;
				end
			end
			cal_pkg::REQ_SET: begin
				unique case (req.field_select)
					cal_pkg::FLD_HOUR:   nxt.hour   = req.set_value;
					cal_pkg::FLD_MINUTE: nxt.minute = req.set_value;
					cal_pkg::FLD_SECOND: nxt.second = req.set_value;
					cal_pkg::FLD_YEAR:   nxt.year   = req.set_value;
					cal_pkg::FLD_MONTH: begin
						if (month_ok)
							nxt.month = req.set_value[3:0];
					end
					cal_pkg::FLD_DAY: begin
						if (day_ok)
							nxt.day = req.set_value[4:0];
					end
					cal_pkg::FLD_WEEKDAY: begin
						if (weekday_ok)
							nxt.weekday = req.set_value[2:0];
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/calendar_date_counter_unit.sv =====
// Top level of the calendar date counter: input register, calendar state, result register.
// Depends on cal_pkg, cal_cfg and cal_next.
//
//  Channel  Direction  Transaction content
//  s_*      in         tdata: set_value[15:0]; tuser: req_type[1:0], field_select[4:2]
//  m_*      out        tdata: hour, minute, second, year, month, day, weekday (low first)
//                      in 80 bits with zero padding; tuser: advanced[0]
//  APB      in/out     run_paused at 0x0, prescale_limit at 0x4
//
// One request per clock is sustained while m_tready stays high. A request is held in the
// input register, where the calendar logic reads and updates the state, and the answer is
// registered in the result register, which drives m_tvalid.
// A stalled m_tready holds the result and the input register; s_tready drops only when
// both are full. Reset (arst_n low) empties both and loads the calendar reset values.
`default_nettype none

module calendar_date_counter_unit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	input  wire logic [15:0]                s_tdata,  // set_value[15:0]
	input  wire logic [4:0]                 s_tuser,  // req_type[1:0], field_select[4:2]
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	// hour_now[15:0], minute_now[31:16], second_now[47:32], year_now[63:48],
	// month_now[67:64], day_now[72:68], weekday_now[75:73], zero[79:76]
	output logic      [79:0]                m_tdata,
	output logic      [0:0]                 m_tuser,  // advanced[0]
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [cal_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output logic      [31:0]                prdata,
	output logic                            pready
);

	cal_pkg::cal_cfg_t   cfg;
	cal_pkg::cal_req_t   req_s1;
	logic                valid_s1;
	cal_pkg::cal_state_t state_q;
	cal_pkg::cal_state_t state_nxt;
	cal_pkg::cal_state_t out_q;
	logic                adv_nxt;
	logic                adv_q;
	logic                out_valid_q;
	logic                fire_s1;
	logic                accept_in;

	cal_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cal_next u_next (
		.cfg      (cfg),
		.cur      (state_q),
		.req      (req_s1),
		.nxt      (state_nxt),
		.advanced (adv_nxt)
	);

	// The staged request is processed when the result register is free or being drained.
	assign fire_s1   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || fire_s1;
	assign accept_in = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept_in)
				valid_s1 <= 1'b1;
			else if (fire_s1)
				valid_s1 <= 1'b0;
			if (fire_s1)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			req_s1.req_type     <= s_tuser[1:0];
			req_s1.field_select <= s_tuser[4:2];
			req_s1.set_value    <= s_tdata;
		end
		if (fire_s1) begin
			out_q <= state_nxt;
			adv_q <= adv_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.prescale_count <= 10'd0;
			state_q.hour           <= 16'sd0;
			state_q.minute         <= 16'sd0;
			state_q.second         <= 16'sd0;
			state_q.year           <= cal_pkg::YEAR_RST;
			state_q.month          <= cal_pkg::MONTH_JAN;
			state_q.day            <= cal_pkg::DAY_FIRST;
			state_q.weekday        <= cal_pkg::WEEKDAY_FIRST;
		end else if (fire_s1) begin
			state_q <= state_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_q.weekday, out_q.day, out_q.month, out_q.year,
		out_q.second, out_q.minute, out_q.hour};
	assign m_tuser  = adv_q;

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for calendar_date_counter_unit: requests on the s_* stream,
// calendar snapshots checked on the m_* stream, registers written over APB.
// Depends on cal_pkg and the calendar_date_counter_unit RTL.
`timescale 1ns / 100ps

module tb;

	localparam logic [1:0] REQ_UNKNOWN    = 2'd3;
	localparam logic [2:0] FLD_NONE       = 3'd7;
	localparam int         DRAIN_CYCLES   = 4;
	localparam int         HOLD_CYCLES    = 300;
	localparam int         WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		logic [15:0] hour;
		logic [15:0] minute;
		logic [15:0] second;
		logic [15:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [2:0]  weekday;
		logic        advanced;
	} cal_view_t;

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [15:0] s_tdata;  // set_value[15:0]
	logic [4:0] s_tuser;   // req_type[1:0], field_select[4:2]
	logic m_tvalid;
	logic m_tready;
	// hour, minute, second, year, month, day, weekday from bit 0 up, zero padded
	logic [79:0] m_tdata;
	logic [0:0] m_tuser;   // advanced[0]
	logic psel;
	logic penable;
	logic pwrite;
	logic [cal_pkg::ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	cal_pkg::cal_state_t cal_now;
	cal_pkg::cal_cfg_t   cfg_now;
	cal_view_t           calendar_views_q[$];

	bit idle_on;
	bit hold_request;
	int n_errors;
	int n_sent;
	int n_checked;
	int n_advances;
	int n_year_rolls;
	int n_leap_days;
	int n_settings;

	calendar_date_counter_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #1 clk = ~clk;

	// Applies one request to the local calendar and returns the snapshot it answers with.
	task automatic calendar_step(input logic [1:0] req, input logic [2:0] sel,
			input logic [15:0] val, output cal_view_t view);
		int sv;
		int next_day;
		int yr;
		int mlen;
		bit leap;
		logic adv;
		sv = int'($signed(val));
		adv = 1'b0;
		case (req)
			cal_pkg::REQ_TICK: begin
				if (cal_now.prescale_count >= cfg_now.prescale_limit
						&& !cfg_now.run_paused) begin
					cal_now.prescale_count = '0;
					adv = 1'b1;
					n_advances++;
					cal_now.second = cal_now.second + 16'sd1;
					cal_now.weekday = (cal_now.weekday >= cal_pkg::WEEKDAY_LAST)
						? cal_pkg::WEEKDAY_FIRST : cal_now.weekday + 3'd1;
					yr = int'(cal_now.year);
					leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
					case (cal_now.month)
						cal_pkg::MONTH_FEB: mlen = leap ? 29 : 28;
						4'd4, 4'd6, 4'd9, 4'd11: mlen = 30;
						default: mlen = 31;
					endcase
					next_day = int'(cal_now.day) + 1;
					if (next_day > mlen) begin
						next_day = 1;
						if (cal_now.month >= cal_pkg::MONTH_DEC) begin
							cal_now.month = cal_pkg::MONTH_JAN;
							cal_now.year = cal_now.year + 16'd1;
							n_year_rolls++;
						end else begin
							cal_now.month = cal_now.month + 4'd1;
						end
					end
					cal_now.day = next_day[4:0];
					if (cal_now.month == cal_pkg::MONTH_FEB && next_day == 29)
						n_leap_days++;
				end else if (cal_now.prescale_count < cfg_now.prescale_limit) begin
					cal_now.prescale_count = cal_now.prescale_count + 10'd1;
				end
			end
			cal_pkg::REQ_SET: begin
				case (sel)
					cal_pkg::FLD_HOUR:   cal_now.hour = val;
					cal_pkg::FLD_MINUTE: cal_now.minute = val;
					cal_pkg::FLD_SECOND: cal_now.second = val;
					cal_pkg::FLD_YEAR:   cal_now.year = val;
					cal_pkg::FLD_MONTH:   if (sv >= 1 && sv <= 12) cal_now.month = val[3:0];
					cal_pkg::FLD_DAY:     if (sv >= 1 && sv <= 31) cal_now.day = val[4:0];
					cal_pkg::FLD_WEEKDAY: if (sv >= 1 && sv <= 7) cal_now.weekday = val[2:0];
					default: ;
				endcase
			end
			default: ;
		endcase
		view.hour = cal_now.hour;
		view.minute = cal_now.minute;
		view.second = cal_now.second;
		view.year = cal_now.year;
		view.month = cal_now.month;
		view.day = cal_now.day;
		view.weekday = cal_now.weekday;
		view.advanced = adv;
	endtask

	// Offers one request, optionally after a random gap, and records its expected answer.
	task automatic send_request(input logic [1:0] req, input logic [2:0] sel,
			input logic [15:0] val);
		cal_view_t view;
		int gap;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 16);
			repeat (gap) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
			end
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= {sel, req};
		s_tdata <= val;
		do @(posedge clk); while (!s_tready);
		calendar_step(req, sel, val, view);
		calendar_views_q.push_back(view);
		n_sent++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (calendar_views_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic regsel, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {regsel, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (regsel == cal_pkg::REG_RUN_PAUSED)
			cfg_now.run_paused = value[0];
		else
			cfg_now.prescale_limit = value[9:0];
		n_settings++;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Mostly tick bursts and complete date setups near month ends, plus malformed requests.
	task automatic random_traffic(input int n_items);
		int sent;
		int burst;
		int small_val;
		logic [15:0] yr;
		logic [15:0] mon;
		sent = 0;
		while (sent < n_items) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					burst = $urandom_range(1, 12);
					repeat (burst)
						send_request(cal_pkg::REQ_TICK, 3'($urandom_range(0, 7)),
							16'($urandom));
					sent += burst;
				end
				6, 7: begin
					case ($urandom_range(0, 7))
						0: yr = 16'd1900;
						1: yr = 16'd2000;
						2: yr = 16'd2100;
						3: yr = 16'd2024;
						4: yr = 16'd2023;
						5: yr = 16'hFFFF;
						6: yr = 16'd0;
						default: yr = 16'($urandom);
					endcase
					mon = ($urandom_range(0, 2) == 0) ? 16'(cal_pkg::MONTH_FEB)
						: 16'($urandom_range(1, 12));
					send_request(cal_pkg::REQ_SET, cal_pkg::FLD_YEAR, yr);
					send_request(cal_pkg::REQ_SET, cal_pkg::FLD_MONTH, mon);
					send_request(cal_pkg::REQ_SET, cal_pkg::FLD_DAY,
						16'($urandom_range(25, 31)));
					send_request(cal_pkg::REQ_SET, cal_pkg::FLD_WEEKDAY,
						16'($urandom_range(1, 7)));
					sent += 4;
				end
				8: begin
					small_val = int'($urandom_range(0, 40)) - 4;
					send_request(cal_pkg::REQ_SET, 3'($urandom_range(0, 7)),
						($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'(small_val));
					sent++;
				end
				default: begin
					send_request(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
						16'($urandom));
					sent++;
				end
			endcase
		end
	endtask

	task automatic test_reset_values();
		send_request(cal_pkg::REQ_READ, cal_pkg::FLD_HOUR, 16'h0000);
		send_request(REQ_UNKNOWN, cal_pkg::FLD_YEAR, 16'h1234);
	endtask

	// Every field at its extremes, with out-of-range month, day and weekday values ignored.
	task automatic test_field_writes();
		send_request(cal_pkg::REQ_SET, cal_pkg::FLD_HOUR, 16'h7FFF);
		send_request(cal_pkg::REQ_SET, cal_pkg::FLD_MINUTE, 16'h8000);
		send_request(cal_pkg::REQ_SET, cal_pkg::FLD_SECOND, 16'hFFFF);
		send_request(cal_pkg::REQ_SET, cal_pkg::FLD_YEAR, 16'hFFFF);
		send_request(cal_pkg::REQ_SET, cal_pkg::FLD_MONTH, 16'd0);
		send_request(cal_pkg::REQ_SET, cal_pkg::FLD_MONTH, 16'd13);
		send_request(cal_pkg::REQ_SET, cal_pkg::FLD_MONTH, 16'd12);
		send_request(cal_pkg::REQ_SET, cal_pkg::FLD_DAY, 16'd0);
		send_request(cal_pkg::REQ_SET, cal_pkg::FLD_DAY, 16'd32);
		send_request(cal_pkg::REQ_SET, cal_pkg::FLD_DAY, 16'd31);
		send_request(cal_pkg::REQ_SET, cal_pkg::FLD_WEEKDAY, 16'd0);
		send_request(cal_pkg::REQ_SET, cal_pkg::FLD_WEEKDAY, 16'd8);
		send_request(cal_pkg::REQ_SET, cal_pkg::FLD_WEEKDAY, 16'd7);
		send_request(cal_pkg::REQ_SET, FLD_NONE, 16'd5);
		send_request(cal_pkg::REQ_TICK, cal_pkg::FLD_HOUR, 16'hA5A5);
	endtask

	// With a zero limit every tick advances: second, weekday, day, month and year all wrap.
	// Then a day set past the end of a leap February rolls over to March.
	task automatic test_rollover();
		wait_idle();
		cfg_write(cal_pkg::REG_PRESCALE_LIMIT, 32'd0);
		send_request(cal_pkg::REQ_TICK, cal_pkg::FLD_HOUR, 16'h0000);
		send_request(cal_pkg::REQ_SET, cal_pkg::FLD_MONTH, 16'(cal_pkg::MONTH_FEB));
		send_request(cal_pkg::REQ_SET, cal_pkg::FLD_DAY, 16'(cal_pkg::DAY_MAX));
		send_request(cal_pkg::REQ_TICK, cal_pkg::FLD_HOUR, 16'h0000);
	endtask

	// A paused count below the top limit, then the limit lowered beneath the count.
	task automatic test_count_above_limit();
		wait_idle();
		cfg_write(cal_pkg::REG_RUN_PAUSED, 32'd1);
		cfg_write(cal_pkg::REG_PRESCALE_LIMIT, 32'd1023);
		repeat (3) send_request(cal_pkg::REQ_TICK, cal_pkg::FLD_HOUR, 16'h0000);
		wait_idle();
		cfg_write(cal_pkg::REG_PRESCALE_LIMIT, 32'd1);
		send_request(cal_pkg::REQ_TICK, cal_pkg::FLD_HOUR, 16'h0000);
		wait_idle();
		cfg_write(cal_pkg::REG_RUN_PAUSED, 32'd0);
		send_request(cal_pkg::REQ_TICK, cal_pkg::FLD_HOUR, 16'h0000);
	endtask

	// The receiver holds off while the sender keeps offering until the input stalls.
	task automatic test_backpressure();
		wait_idle();
		idle_on = 1'b0;
		hold_request = 1'b1;
		random_traffic(24);
		idle_on = 1'b1;
	endtask

	task automatic test_random_phases();
		int phase;
		int limit;
		for (phase = 0; phase < 9; phase++) begin
			wait_idle();
			case ($urandom_range(0, 7))
				0, 1: limit = 0;
				2: limit = 1;
				3: limit = 2;
				4: limit = 3;
				5: limit = $urandom_range(4, 9);
				6: limit = 1023;
				default: limit = int'(cal_pkg::PRESCALE_LIMIT_RST);
			endcase
			cfg_write(cal_pkg::REG_PRESCALE_LIMIT, ($urandom & ~32'h3FF) | 32'(limit));
			cfg_write(cal_pkg::REG_RUN_PAUSED,
				($urandom & ~32'h1) | 32'($urandom_range(0, 4) == 0));
			random_traffic(190);
		end
	endtask

	task automatic test_steady_stream();
		wait_idle();
		cfg_write(cal_pkg::REG_RUN_PAUSED, 32'd0);
		cfg_write(cal_pkg::REG_PRESCALE_LIMIT, 32'd0);
		idle_on = 1'b0;
		random_traffic(200);
	endtask

	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected 0x%04h, actual 0x%04h", name, want, got);
			n_errors++;
		end
	endfunction

	always @(posedge clk) begin : check_response
		cal_view_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (calendar_views_q.size() == 0) begin
				$error("Output transaction with no request outstanding");
				n_errors++;
			end else begin
				want = calendar_views_q.pop_front();
				check_field("hour_now", want.hour, m_tdata[15:0]);
				check_field("minute_now", want.minute, m_tdata[31:16]);
				check_field("second_now", want.second, m_tdata[47:32]);
				check_field("year_now", want.year, m_tdata[63:48]);
				check_field("month_now", 16'(want.month), 16'(m_tdata[67:64]));
				check_field("day_now", 16'(want.day), 16'(m_tdata[72:68]));
				check_field("weekday_now", 16'(want.weekday), 16'(m_tdata[75:73]));
				check_field("advanced", 16'(want.advanced), 16'(m_tuser[0]));
				n_checked++;
			end
		end
	end

	// Receiver: random ready bursts, and a long hold when a test asks for one.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_request = 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(0, 15)) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
				quiet = 0;
			else
				quiet++;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("Timeout after %0d cycles without a transaction", quiet);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		idle_on = 1'b1;
		hold_request = 1'b0;
		cal_now = '0;
		cal_now.year = cal_pkg::YEAR_RST;
		cal_now.month = cal_pkg::MONTH_JAN;
		cal_now.day = cal_pkg::DAY_FIRST;
		cal_now.weekday = cal_pkg::WEEKDAY_FIRST;
		cfg_now.run_paused = 1'b0;
		cfg_now.prescale_limit = cal_pkg::PRESCALE_LIMIT_RST;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_values();
		test_field_writes();
		test_rollover();
		test_count_above_limit();
		test_backpressure();
		test_random_phases();
		test_steady_stream();

		wait_idle();
		repeat (8) @(posedge clk);
		$display("Sent %0d requests and checked %0d snapshots across %0d register writes.",
			n_sent, n_checked, n_settings);
		$display("The calendar advanced %0d times, rolled the year %0d times, hit %0d leap days.",
			n_advances, n_year_rolls, n_leap_days);
		if (n_errors == 0 && calendar_views_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/cal_pkg.sv
hw/rtl/cal_cfg.sv
hw/rtl/cal_next.sv
hw/rtl/calendar_date_counter_unit.sv
verif/tb.sv
